// ===== rtl/core/opnt_pkg.sv =====
// shared types, constants and helpers for the onset pitch note tracker
`default_nettype none

package opnt_pkg;

    localparam int WINDOW      = 6;
    localparam int PITCH_W     = 15;
    localparam int FRAC_W      = 8;
    localparam int LEVEL_W     = 8;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int CNT_W       = 3;
    localparam int RANK_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MEDIAN_RANK = (WINDOW - 1) / 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NOTE_W-1:0] NOTE_FLOOR = 7'd45;
    localparam logic [VEL_W-1:0]  VEL_MAX    = 7'd127;
    localparam logic [VEL_W-1:0]  VEL_OFF    = 7'd0;

    localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = -8'sd90;

    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MEDIAN        = 1'd1;

    // one frame's worth of events: a note-off, optionally followed by a note-on
    typedef struct packed {
        logic              two_events;
        logic [NOTE_W-1:0] off_note;
        logic [NOTE_W-1:0] on_note;
        logic [VEL_W-1:0]  on_vel;
    } cmd_t;

    function automatic logic [VEL_W-1:0] velocity_of(input logic signed [LEVEL_W-1:0] level);
        logic signed [LEVEL_W:0] sum;
        logic [VEL_W-1:0]        res;
        sum = $signed({1'b0, VEL_MAX}) + $signed({level[LEVEL_W-1], level});
        if (sum < 0)
        begin
            res = VEL_OFF;
        end
        else if (sum > $signed({2'b00, VEL_MAX}))
        begin
            res = VEL_MAX;
        end
        else
        begin
            res = sum[VEL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/opnt_in_if.sv =====
// frame input channel
`default_nettype none

interface opnt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [opnt_pkg::PITCH_W-1:0]           pitch;
    logic                                   onset_flag;
    logic signed [opnt_pkg::LEVEL_W-1:0]    level_db;

    modport source (output valid, output pitch, output onset_flag, output level_db,
                    input ready);
    modport sink   (input valid, input pitch, input onset_flag, input level_db,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/opnt_out_if.sv =====
// note event output channel
`default_nettype none

interface opnt_out_if;
    logic                           valid;
    logic                           ready;
    logic [opnt_pkg::NOTE_W-1:0]    note_number;
    logic [opnt_pkg::VEL_W-1:0]     velocity;
    logic                           last;

    modport source (output valid, output note_number, output velocity, output last,
                    input ready);
    modport sink   (input valid, input note_number, input velocity, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/opnt_front.sv =====
// front end: config registers, pitch window, median and note decision per frame
`default_nettype none

module opnt_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [opnt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [opnt_pkg::CFG_DATA_W-1:0]    cfg_data,
    opnt_in_if.sink                                 in_ch,
    input  wire logic                               q_full,
    output      logic                               push,
    output      opnt_pkg::cmd_t                     push_cmd
);

    logic signed [opnt_pkg::LEVEL_W-1:0] thr_reg;
    logic                                use_median_reg;
    logic [opnt_pkg::PITCH_W-1:0]        win_reg [opnt_pkg::WINDOW];
    logic [opnt_pkg::PITCH_W-1:0]        win_new [opnt_pkg::WINDOW];
    logic [opnt_pkg::NOTE_W-1:0]         note_reg;
    logic [opnt_pkg::NOTE_W-1:0]         note_next;
    logic [opnt_pkg::CNT_W-1:0]          count_reg;
    logic [opnt_pkg::CNT_W-1:0]          count_next;
    logic [opnt_pkg::CNT_W:0]            count_inc;
    logic [opnt_pkg::RANK_W-1:0]         rank [opnt_pkg::WINDOW];
    logic [opnt_pkg::PITCH_W-1:0]        median_pitch;
    logic [opnt_pkg::NOTE_W-1:0]         median_note;
    logic [opnt_pkg::NOTE_W-1:0]         new_note;
    logic                                accept;
    logic                                silent;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign silent      = in_ch.level_db < thr_reg;
    assign new_note    = in_ch.pitch[opnt_pkg::PITCH_W-1:opnt_pkg::FRAC_W];
    assign count_inc   = {1'b0, count_reg} + {{opnt_pkg::CNT_W{1'b0}}, 1'b1};

    // window as it stands once this frame's pitch is shifted in
    always_comb
    begin
        for (int i = 0; i < opnt_pkg::WINDOW - 1; i++)
        begin
            win_new[i] = win_reg[i+1];
        end
        win_new[opnt_pkg::WINDOW-1] = in_ch.pitch;
    end

    // lower median by rank: count smaller entries, ties broken by position
    always_comb
    begin
        for (int i = 0; i < opnt_pkg::WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < opnt_pkg::WINDOW; j++)
            begin
                if (j != i && (win_new[j] < win_new[i] ||
                               (win_new[j] == win_new[i] && j < i)))
                begin
                    rank[i] = rank[i] + opnt_pkg::RANK_W'(1);
                end
            end
        end
        median_pitch = '0;
        for (int i = 0; i < opnt_pkg::WINDOW; i++)
        begin
            if (rank[i] == opnt_pkg::RANK_W'(opnt_pkg::MEDIAN_RANK))
            begin
                median_pitch = win_new[i];
            end
        end
    end

    assign median_note = median_pitch[opnt_pkg::PITCH_W-1:opnt_pkg::FRAC_W];

    always_comb
    begin
        push       = 1'b0;
        push_cmd   = '0;
        note_next  = note_reg;
        count_next = count_reg;
        push_cmd.off_note = note_reg;
        if (accept)
        begin
            if (in_ch.onset_flag)
            begin
                if (silent)
                begin
                    if (use_median_reg)
                    begin
                        count_next = '0;
                    end
                    push = 1'b1;
                end
                else if (use_median_reg)
                begin
                    count_next = opnt_pkg::CNT_W'(1);
                end
                else
                begin
                    push                = 1'b1;
                    push_cmd.two_events = 1'b1;
                    push_cmd.on_note    = new_note;
                    push_cmd.on_vel     = opnt_pkg::velocity_of(in_ch.level_db);
                    note_next           = new_note;
                end
            end
            else if (use_median_reg && count_reg != '0)
            begin
                if (count_inc == (opnt_pkg::CNT_W+1)'(opnt_pkg::WINDOW))
                begin
                    push                = 1'b1;
                    push_cmd.two_events = median_note > opnt_pkg::NOTE_FLOOR;
                    push_cmd.on_note    = median_note;
                    // silent frame counts as +1 dB, which saturates
                    push_cmd.on_vel     = silent ? opnt_pkg::VEL_MAX
                                                 : opnt_pkg::velocity_of(in_ch.level_db);
                    note_next           = median_note;
                end
                if (count_inc >= (opnt_pkg::CNT_W+1)'(opnt_pkg::WINDOW))
                begin
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc[opnt_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= opnt_pkg::THRESHOLD_RESET;
            use_median_reg <= 1'b1;
            note_reg       <= '0;
            count_reg      <= '0;
            for (int i = 0; i < opnt_pkg::WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    opnt_pkg::REG_SILENCE_THRESHOLD: thr_reg <= $signed(cfg_data);
                    opnt_pkg::REG_USE_MEDIAN:        use_median_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            note_reg  <= note_next;
            count_reg <= count_next;
            if (accept && use_median_reg)
            begin
                for (int i = 0; i < opnt_pkg::WINDOW; i++)
                begin
                    win_reg[i] <= win_new[i];
                end
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < opnt_pkg::CNT_W'(opnt_pkg::WINDOW))
        else $error("ready count left its range");

    a_direct_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !use_median_reg && !cfg_we) |=> count_reg == $past(count_reg))
        else $error("direct mode changed the ready count");

endmodule

`default_nettype wire

// ===== rtl/core/opnt_queue.sv =====
// short command queue between front and back
`default_nettype none

module opnt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire opnt_pkg::cmd_t     push_cmd,
    output      logic               full,
    input  wire logic               pop,
    output      opnt_pkg::cmd_t     pop_cmd,
    output      logic               empty
);

    opnt_pkg::cmd_t                  mem_reg [opnt_pkg::QUEUE_DEPTH];
    logic [opnt_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [opnt_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [opnt_pkg::QCNT_W-1:0]     count_reg;
    logic [opnt_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [opnt_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = count_reg == opnt_pkg::QCNT_W'(opnt_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == opnt_pkg::QPTR_W'(opnt_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_reg + opnt_pkg::QPTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == opnt_pkg::QPTR_W'(opnt_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_reg + opnt_pkg::QPTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + opnt_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - opnt_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= opnt_pkg::QCNT_W'(opnt_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/opnt_back.sv =====
// back end: expands queued commands into note events behind an output register
`default_nettype none

module opnt_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    input  wire opnt_pkg::cmd_t     pop_cmd,
    output      logic               pop,
    opnt_out_if.source              out_ch
);

    logic                            out_valid_reg;
    logic [opnt_pkg::NOTE_W-1:0]     out_note_reg;
    logic [opnt_pkg::VEL_W-1:0]      out_vel_reg;
    logic                            out_last_reg;
    logic                            pend_reg;
    logic [opnt_pkg::NOTE_W-1:0]     pend_note_reg;
    logic [opnt_pkg::VEL_W-1:0]      pend_vel_reg;
    logic                            can_load;

    assign can_load = !out_valid_reg || out_ch.ready;
    assign pop      = can_load && !pend_reg && !empty;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.note_number = out_note_reg;
    assign out_ch.velocity    = out_vel_reg;
    assign out_ch.last        = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (!empty)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= pop_cmd.two_events;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_reg)
            begin
                out_note_reg <= pend_note_reg;
                out_vel_reg  <= pend_vel_reg;
                out_last_reg <= 1'b1;
            end
            else if (!empty)
            begin
                // note-off goes first, the note-on waits one transfer
                out_note_reg  <= pop_cmd.off_note;
                out_vel_reg   <= opnt_pkg::VEL_OFF;
                out_last_reg  <= !pop_cmd.two_events;
                pend_note_reg <= pop_cmd.on_note;
                pend_vel_reg  <= pop_cmd.on_vel;
            end
        end
    end

    a_pend_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("pending note-on without a note-off in front");

    a_not_last_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> pend_reg)
        else $error("event not marked last but nothing follows");

endmodule

`default_nettype wire

// ===== rtl/core/onset_pitch_note_tracker.sv =====
// top level of the onset pitch note tracker
// the first event of a frame passes through the command queue and the output register,
//   a second event of the same frame follows it from the pending register
// throughput: one frame per cycle into a two-entry command queue while it has room; the
//   output register moves one event per cycle while the receiver is ready
// reset: threshold -90 dB, median mode, pitch window, note and ready count cleared
`default_nettype none

module onset_pitch_note_tracker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [opnt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [opnt_pkg::CFG_DATA_W-1:0]    cfg_data,
    opnt_in_if.sink                                 in_ch,
    opnt_out_if.source                              out_ch
);

    logic           push;
    opnt_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           pop;
    opnt_pkg::cmd_t pop_cmd;
    logic           q_empty;

    opnt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    opnt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    opnt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (q_empty),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the onset pitch note tracker
`default_nettype none

module testbench;

    import opnt_pkg::*;

    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_FRAMES = 165;

    typedef struct packed {
        logic [PITCH_W-1:0]        pitch;
        logic                      onset;
        logic signed [LEVEL_W-1:0] level;
    } frame_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              last;
    } note_ev_t;

    logic                  clk;
    logic                  rst_n = 1'b1;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    opnt_in_if  in_ch ();
    opnt_out_if out_ch ();

    onset_pitch_note_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // tracker model: window, sounding note, arm counter and register copies
    logic [PITCH_W-1:0]        pwin [WINDOW];
    logic [NOTE_W-1:0]         held_note;
    logic [CNT_W-1:0]          arm_count;
    logic signed [LEVEL_W-1:0] thr_m;
    logic                      median_m;

    frame_t   frame_q [$];
    note_ev_t note_events [$];
    frame_t   offered;

    bit idle_on;
    int in_gap;
    int out_gap;
    int stall_left;
    int hold_asked;
    int hold_served;
    int mismatch_cnt;
    int frames_taken;
    int ons_seen;
    int offs_seen;
    int phases_run;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
        begin
            $display("error: %s", msg);
        end
    endtask

    function automatic logic [VEL_W-1:0] level_to_vel(input int lvl);
        int v;
        v = 127 + lvl;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 127)
        begin
            v = 127;
        end
        return v[VEL_W-1:0];
    endfunction

    function automatic logic [NOTE_W-1:0] window_median();
        logic [PITCH_W-1:0] srt [WINDOW];
        logic [PITCH_W-1:0] t;
        int i;
        int j;
        for (i = 0; i < WINDOW; i++)
        begin
            srt[i] = pwin[i];
        end
        for (i = 0; i < WINDOW - 1; i++)
        begin
            for (j = 0; j < WINDOW - 1 - i; j++)
            begin
                if (srt[j] > srt[j + 1])
                begin
                    t = srt[j];
                    srt[j] = srt[j + 1];
                    srt[j + 1] = t;
                end
            end
        end
        return srt[MEDIAN_RANK][PITCH_W-1:FRAC_W];
    endfunction

    // advance the model by one frame and queue the note events it causes
    function automatic void track_frame(input frame_t f);
        note_ev_t          ev [2];
        logic              silent;
        logic [NOTE_W-1:0] fresh;
        int                lvl;
        int                n;
        int                nxt;
        int                k;
        lvl = $signed(f.level);
        silent = $signed(f.level) < $signed(thr_m);
        fresh = f.pitch[PITCH_W-1:FRAC_W];
        n = 0;
        if (median_m)
        begin
            for (k = 0; k < WINDOW - 1; k++)
            begin
                pwin[k] = pwin[k + 1];
            end
            pwin[WINDOW-1] = f.pitch;
        end
        if (f.onset)
        begin
            if (silent)
            begin
                if (median_m)
                begin
                    arm_count = '0;
                end
                ev[n].note = held_note;
                ev[n].vel = VEL_OFF;
                n++;
            end
            else if (median_m)
            begin
                arm_count = 1;
            end
            else
            begin
                ev[0].note = held_note;
                ev[0].vel = VEL_OFF;
                ev[1].note = fresh;
                ev[1].vel = level_to_vel(lvl);
                n = 2;
                held_note = fresh;
            end
        end
        else if (median_m && arm_count != 0)
        begin
            nxt = int'(arm_count) + 1;
            if (nxt == WINDOW)
            begin
                ev[n].note = held_note;
                ev[n].vel = VEL_OFF;
                n++;
                held_note = window_median();
                if (held_note > NOTE_FLOOR)
                begin
                    // a silent frame counts as +1 dB here
                    ev[n].note = held_note;
                    ev[n].vel = level_to_vel(silent ? 1 : lvl);
                    n++;
                end
            end
            arm_count = (nxt >= WINDOW) ? '0 : nxt[CNT_W-1:0];
        end
        for (k = 0; k < n; k++)
        begin
            ev[k].last = (k == n - 1);
            note_events.push_back(ev[k]);
        end
    endfunction

    // frame driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.pitch <= '0;
            in_ch.onset_flag <= 1'b0;
            in_ch.level_db <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_frame(offered);
                frames_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (frame_q.size() > 0)
                begin
                    offered = frame_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.pitch <= offered.pitch;
                    in_ch.onset_flag <= offered.onset;
                    in_ch.level_db <= offered.level;
                    if (idle_on && $urandom_range(0, 9) == 0)
                    begin
                        in_gap = $urandom_range(1, 10);
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // event monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        note_ev_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (note_events.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected event note %0d vel %0d last %0b",
                        out_ch.note_number, out_ch.velocity, out_ch.last));
                end
                else
                begin
                    want = note_events.pop_front();
                    if (want.vel == VEL_OFF)
                    begin
                        offs_seen++;
                    end
                    else
                    begin
                        ons_seen++;
                    end
                    if (out_ch.note_number !== want.note)
                    begin
                        flag_mismatch($sformatf("note_number %0d, expected %0d",
                            out_ch.note_number, want.note));
                    end
                    if (out_ch.velocity !== want.vel)
                    begin
                        flag_mismatch($sformatf("velocity %0d, expected %0d",
                            out_ch.velocity, want.vel));
                    end
                    if (out_ch.last !== want.last)
                    begin
                        flag_mismatch($sformatf("last %0b, expected %0b",
                            out_ch.last, want.last));
                    end
                end
            end
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                begin
                    out_gap = $urandom_range(1, 10);
                end
            end
        end
    end

    // ends the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_frame(input int pitch, input bit onset, input int lvl);
        frame_t f;
        f.pitch = pitch[PITCH_W-1:0];
        f.onset = onset;
        f.level = lvl[LEVEL_W-1:0];
        frame_q.push_back(f);
    endtask

    function automatic int pick_pitch();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(0, (46 << FRAC_W) - 1);
        end
        return $urandom_range(0, 32767);
    endfunction

    function automatic int pick_level(input int thr);
        case ($urandom_range(0, 3))
            0: return thr;
            1: return (thr > -128) ? thr - 1 : -128;
            default: return -int'($urandom_range(0, 128));
        endcase
    endfunction

    // wait until the block has drained, then give it time to finish frames without events
    task automatic settle();
        do
        begin
            @(negedge clk);
        end
        while (frame_q.size() != 0 || in_ch.valid || note_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int thr, input bit med);
        write_reg(REG_SILENCE_THRESHOLD, thr[CFG_DATA_W-1:0]);
        write_reg(REG_USE_MEDIAN, {{(CFG_DATA_W-1){1'b0}}, med});
        thr_m = thr[LEVEL_W-1:0];
        median_m = med;
        phases_run++;
        @(negedge clk);
    endtask

    // mostly onset-plus-tail sequences that let the median fire, some noise in between
    task automatic fill_random(input int count, input int thr);
        int made;
        int tail;
        int k;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    add_frame(pick_pitch(), 1'b1, pick_level(thr));
                end
                else
                begin
                    add_frame(pick_pitch(), 1'b1, thr + int'($urandom_range(0, -thr)));
                end
                tail = $urandom_range(3, 8);
                for (k = 0; k < tail; k++)
                begin
                    add_frame(pick_pitch(), 1'b0, pick_level(thr));
                end
                made += 1 + tail;
            end
            else
            begin
                tail = $urandom_range(1, 4);
                for (k = 0; k < tail; k++)
                begin
                    add_frame(pick_pitch(), $urandom_range(0, 1), pick_level(thr));
                end
                made += tail;
            end
        end
    endtask

    initial
    begin
        int thr;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            pwin[i] = '0;
        end
        held_note = '0;
        arm_count = '0;
        thr_m = THRESHOLD_RESET;
        median_m = 1'b1;
        idle_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // median mode at reset values: firing on a silent frame
        add_frame(16'h3C80, 1'b1, -10);
        add_frame(16'h3D00, 1'b0, -90);
        add_frame(16'h3B40, 1'b0, -90);
        add_frame(16'h7FFF, 1'b0, 0);
        add_frame(16'h0000, 1'b0, -1);
        add_frame(16'h3E00, 1'b0, -128);
        // onset in silence, then a frame that must stay quiet
        add_frame(16'h4000, 1'b1, -91);
        add_frame(16'h4100, 1'b0, -20);
        // median lands on the note floor, so only the note-off goes out
        add_frame(16'h2D00, 1'b1, 0);
        add_frame(16'h2DFF, 1'b0, 0);
        add_frame(16'h1000, 1'b0, 0);
        add_frame(16'h2D80, 1'b0, 0);
        add_frame(16'h0100, 1'b0, 0);
        add_frame(16'h7F00, 1'b0, 0);
        // re-arm on a second onset, leave the count running across the mode switch
        add_frame(16'h5000, 1'b1, -50);
        add_frame(16'h5200, 1'b1, -20);
        add_frame(16'h5300, 1'b0, -30);
        add_frame(16'h5400, 1'b0, -40);
        add_frame(16'h5500, 1'b0, -60);
        settle();

        apply_setting(-90, 1'b0);
        add_frame(16'h7FFF, 1'b1, 0);
        add_frame(16'h0000, 1'b1, -127);
        add_frame(16'h3000, 1'b1, -128);
        add_frame(16'h3100, 1'b0, -10);
        add_frame(16'h2C00, 1'b1, -90);
        settle();

        apply_setting(-128, 1'b1);
        fill_random(PHASE_FRAMES, -128);
        settle();

        apply_setting(0, 1'b1);
        fill_random(PHASE_FRAMES, 0);
        settle();

        thr = -int'($urandom_range(0, 128));
        apply_setting(thr, 1'b0);
        fill_random(PHASE_FRAMES, thr);
        settle();

        apply_setting(-128, 1'b0);
        fill_random(PHASE_FRAMES, -128);
        settle();

        apply_setting(0, 1'b0);
        fill_random(PHASE_FRAMES, 0);
        settle();

        // long receiver stall while frames keep coming
        apply_setting(-60, 1'b1);
        fill_random(PHASE_FRAMES, -60);
        hold_asked++;
        settle();

        // closing phase runs with no driver gaps and the receiver always ready
        idle_on = 1'b0;
        thr = -int'($urandom_range(0, 128));
        apply_setting(thr, 1'b1);
        fill_random(PHASE_FRAMES, thr);
        settle();

        if (note_events.size() != 0)
        begin
            flag_mismatch($sformatf("%0d note events never arrived", note_events.size()));
        end
        $display("coverage: %0d frames over %0d register settings, median and direct modes",
            frames_taken, phases_run);
        $display("events checked: %0d note-on, %0d note-off", ons_seen, offs_seen);
        if (mismatch_cnt == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
